/* hw/rtl/dbs_pkg.sv */
// shared constants, types and helpers of the delimiter byte stuffer
// used by the interfaces, the cell row and the top level
`default_nettype none

package dbs_pkg;

  localparam int MaxPattern = 8;
  localparam int CntW       = $clog2(MaxPattern + 1);
  localparam int IdxW       = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int DupW       = CntW + 1;
  localparam int LenW       = 4;
  localparam int PatW       = 64;
  localparam int CfgIdxW    = 2;

  localparam logic [CfgIdxW-1:0] CfgLength = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBytes  = 2'd1;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic            load;
    logic [IdxW-1:0] load_pos;
    logic            shift;
  } row_ctrl_t;

  typedef struct packed {
    byte_t head;
    logic  prefix_now;
    logic  prefix_next;
  } row_stat_t;

  function automatic byte_t delim_at(input logic [PatW-1:0] pattern,
                                     input logic [IdxW-1:0] idx);
    return pattern[8*idx +: 8];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/dbs_if.sv */
// valid/ready channels for raw input bytes and stuffed output bytes
// depends on dbs_pkg for the byte type
`default_nettype none

interface dbs_in_if;
  logic            valid;
  logic            ready;
  dbs_pkg::byte_t  in_byte;
  logic            message_end;

  modport source (output valid, output in_byte, output message_end, input ready);
  modport sink   (input valid, input in_byte, input message_end, output ready);
endinterface

interface dbs_out_if;
  logic            valid;
  logic            ready;
  dbs_pkg::byte_t  out_byte;
  logic            run_last;
  logic            message_done;

  modport source (output valid, output out_byte, output run_last, output message_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input message_done,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/dbs_cell.sv */
// one cell of the held-byte row: a byte that loads, shifts toward the head
// and compares against its own and its left neighbor's delimiter byte; uses dbs_pkg
`default_nettype none

module dbs_cell (
  input  wire logic                clk_i,
  input  wire dbs_pkg::cell_ctrl_t ctrl_i,
  input  wire dbs_pkg::byte_t      in_byte_i,
  input  wire dbs_pkg::byte_t      right_i,
  input  wire dbs_pkg::byte_t      delim_here_i,
  input  wire dbs_pkg::byte_t      delim_prev_i,
  output dbs_pkg::byte_t           data_o,
  output logic                     eq_here_o,
  output logic                     eq_prev_o
);
  import dbs_pkg::*;

  byte_t data_d, data_q;

  always_comb begin
    priority if (ctrl_i.load) begin
      data_d = in_byte_i;
    end else if (ctrl_i.shift) begin
      data_d = right_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o    = data_q;
  assign eq_here_o = (data_q == delim_here_i);
  assign eq_prev_o = (data_q == delim_prev_i);

endmodule

`default_nettype wire

/* hw/rtl/dbs_row.sv */
// row of held-byte cells with prefix checks of the current and shifted contents
// depends on dbs_pkg and dbs_cell
`default_nettype none

module dbs_row (
  input  wire logic                   clk_i,
  input  wire dbs_pkg::row_ctrl_t     ctrl_i,
  input  wire dbs_pkg::byte_t         in_byte_i,
  input  wire logic [dbs_pkg::PatW-1:0] pattern_i,
  input  wire logic [dbs_pkg::CntW-1:0] cnt_i,
  output dbs_pkg::row_stat_t          stat_o
);
  import dbs_pkg::*;

  byte_t                 data    [MaxPattern];
  logic [MaxPattern-1:0] eq_here;
  logic [MaxPattern-1:0] eq_prev;
  logic                  pfx_now;
  logic                  pfx_next;

  for (genvar k = 0; k < MaxPattern; k++) begin : g_cell
    cell_ctrl_t cctrl;
    byte_t      right;
    byte_t      dprev;

    assign cctrl.load  = ctrl_i.load && (ctrl_i.load_pos == IdxW'(k));
    assign cctrl.shift = ctrl_i.shift;

    if (k < MaxPattern - 1) begin : g_right
      assign right = data[k+1];
    end else begin : g_end
      assign right = '0;
    end

    if (k > 0) begin : g_prev
      assign dprev = pattern_i[8*(k-1) +: 8];
    end else begin : g_first
      assign dprev = '0;
    end

    dbs_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cctrl),
      .in_byte_i    (in_byte_i),
      .right_i      (right),
      .delim_here_i (pattern_i[8*k +: 8]),
      .delim_prev_i (dprev),
      .data_o       (data[k]),
      .eq_here_o    (eq_here[k]),
      .eq_prev_o    (eq_prev[k])
    );
  end

  // live cells are those below the count; shifted view drops cell 0
  always_comb begin
    pfx_now  = 1'b1;
    pfx_next = 1'b1;
    for (int k = 0; k < MaxPattern; k++) begin
      if ((CntW'(k) < cnt_i) && !eq_here[k]) begin
        pfx_now = 1'b0;
      end
      if ((k > 0) && (CntW'(k) < cnt_i) && !eq_prev[k]) begin
        pfx_next = 1'b0;
      end
    end
  end

  assign stat_o.head        = data[0];
  assign stat_o.prefix_now  = pfx_now;
  assign stat_o.prefix_next = pfx_next;

endmodule

`default_nettype wire

/* hw/rtl/delimiter_byte_stuffer_top.sv */
// delimiter byte stuffer: a request is accepted into the cell row and scanned; a result releases
// r bytes, and may end in a flush of f held bytes at message end or in a full match of an L-byte
// delimiter, sent twice as 2L bytes; a stalled output holds the emitting state while the output
// register stays full; requests are taken one request at a time, set by the single output register
// and the shifting cell row
// reset clears the sequencer, the held count and the output valid, length 1, pattern 0
`default_nettype none

module delimiter_byte_stuffer_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [dbs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [dbs_pkg::PatW-1:0]  cfg_wdata_i,
  dbs_in_if.sink                         in_i,
  dbs_out_if.source                      out_o
);
  import dbs_pkg::*;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StScan  = 4'b0010,
    StDup   = 4'b0100,
    StFlush = 4'b1000
  } state_e;

  state_e            state_d, state_q;
  logic [CntW-1:0]   cnt_d, cnt_q;
  logic [DupW-1:0]   dup_d, dup_q;
  logic              end_d, end_q;
  logic [LenW-1:0]   len_q;
  logic [PatW-1:0]   pat_q;

  logic              out_valid_d, out_valid_q;
  byte_t             out_byte_q;
  logic              out_last_q, out_done_q;

  logic              emit, emit_last, emit_done;
  byte_t             emit_byte;
  logic              out_free;

  logic [CntW-1:0]   len_eff;
  logic [CntW-1:0]   cnt_m1;
  logic [DupW-1:0]   len_x, len2, dup_idx;
  logic              pfx_now, pfx_next, more_rel, dup_last;

  row_ctrl_t         row_ctrl;
  row_stat_t         row_stat;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenW'(1);
      pat_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgLength) begin
        len_q <= cfg_wdata_i[LenW-1:0];
      end else if (cfg_idx_i == CfgBytes) begin
        pat_q <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    priority if (len_q == '0) begin
      len_eff = CntW'(1);
    end else if (CntW'(len_q) > CntW'(MaxPattern)) begin
      len_eff = CntW'(MaxPattern);
    end else begin
      len_eff = CntW'(len_q);
    end
  end

  dbs_row u_row (
    .clk_i     (clk_i),
    .ctrl_i    (row_ctrl),
    .in_byte_i (in_i.in_byte),
    .pattern_i (pat_q),
    .cnt_i     (cnt_q),
    .stat_o    (row_stat)
  );

  assign out_free = !out_valid_q || out_o.ready;
  assign cnt_m1   = cnt_q - CntW'(1);
  assign pfx_now  = (cnt_q <= len_eff) && row_stat.prefix_now;
  assign pfx_next = (cnt_m1 <= len_eff) && row_stat.prefix_next;
  // more output follows this release
  assign more_rel = (cnt_m1 != '0) && (!pfx_next || (cnt_m1 == len_eff) || end_q);

  assign len_x    = DupW'(len_eff);
  assign len2     = len_x << 1;
  assign dup_idx  = (dup_q < len_x) ? dup_q : (dup_q - len_x);
  assign dup_last = ((dup_q + DupW'(1)) == len2);

  assign in_i.ready = (state_q == StIdle);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    dup_d     = dup_q;
    end_d     = end_q;
    row_ctrl  = '0;
    emit      = 1'b0;
    emit_byte = row_stat.head;
    emit_last = 1'b0;
    emit_done = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          row_ctrl.load     = 1'b1;
          row_ctrl.load_pos = cnt_q[IdxW-1:0];
          cnt_d             = cnt_q + CntW'(1);
          end_d             = in_i.message_end;
          state_d           = StScan;
        end
      end
      StScan: begin
        if (pfx_now && (cnt_q == len_eff)) begin
          dup_d   = '0;
          state_d = StDup;
        end else if (pfx_now) begin
          state_d = (end_q && (cnt_q != '0)) ? StFlush : StIdle;
        end else if (out_free) begin
          emit           = 1'b1;
          emit_last      = !more_rel;
          emit_done      = !more_rel && end_q;
          row_ctrl.shift = 1'b1;
          cnt_d          = cnt_m1;
          if (!more_rel) begin
            state_d = StIdle;
          end
        end
      end
      StDup: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = delim_at(pat_q, dup_idx[IdxW-1:0]);
          emit_last = dup_last;
          emit_done = dup_last && end_q;
          if (dup_last) begin
            cnt_d   = '0;
            state_d = StIdle;
          end else begin
            dup_d = dup_q + DupW'(1);
          end
        end
      end
      StFlush: begin
        if (out_free) begin
          emit           = 1'b1;
          row_ctrl.shift = 1'b1;
          cnt_d          = cnt_m1;
          if (cnt_q == CntW'(1)) begin
            emit_last = 1'b1;
            emit_done = 1'b1;
            state_d   = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      dup_q   <= '0;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      dup_q   <= dup_d;
      end_q   <= end_d;
    end
  end

  // output register
  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
      out_done_q <= emit_done;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_byte     = out_byte_q;
  assign out_o.run_last     = out_last_q;
  assign out_o.message_done = out_done_q;

  // checks
  a_room_on_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> (cnt_q < CntW'(MaxPattern)))
    else $error("request taken with a full cell row");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (!out_o.message_done || out_o.run_last))
    else $error("message done without run last");

  a_end_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != StIdle) && (state_d == StIdle) && end_q) |=> (cnt_q == '0))
    else $error("bytes still held after message end");

  a_dup_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDup) |-> (dup_q < len2))
    else $error("duplicate counter out of range");

endmodule

`default_nettype wire
